### hw/rtl/idic_pkg.sv
// Shared types, codes and pin helpers for the digital input commander.
`timescale 1ns / 1ps
`default_nettype none

package idic_pkg;

    // Pin count of the inverter; a select equal to this marks a function unassigned.
    localparam logic [2:0] INPUT_PINS = 3'd3;
    // Highest select that still names a level bit.
    localparam logic [1:0] LAST_PIN   = 2'd2;

    typedef enum logic [2:0] {
        CFG_RUN_PIN   = 3'd0,
        CFG_DIR_PIN   = 3'd1,
        CFG_STEP_LOW  = 3'd2,
        CFG_STEP_MID  = 3'd3,
        CFG_STEP_HIGH = 3'd4,
        CFG_DIR_DOM   = 3'd5,
        CFG_STEP_EN   = 3'd6
    } cfg_index_t;

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_TABLE  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        RUN_NONE = 2'd0,
        RUN_HALT = 2'd1,
        RUN_GO   = 2'd2
    } run_cmd_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_cmd_t;

    localparam logic [1:0] DOM_FWD_ONLY = 2'd1;
    localparam logic [1:0] DOM_REV_ONLY = 2'd2;

    typedef struct packed {
        logic [1:0] run_pin;
        logic [1:0] dir_pin;
        logic [1:0] step_low;
        logic [1:0] step_mid;
        logic [1:0] step_high;
        logic [1:0] dir_domain;
        logic       step_en;
    } cfg_t;

    // Drive state carried from sample to sample.
    typedef struct packed {
        logic        run_level;
        logic        dir_level;
        logic [15:0] sent_freq;
    } drive_state_t;

    typedef struct packed {
        logic        freq_write;
        logic [15:0] cmd_freq;
        logic [1:0]  run_command;
        logic [1:0]  direction_command;
        logic [2:0]  step_index;
        logic        edges_handled;
    } result_t;

    function automatic logic pin_assigned(logic [1:0] sel);
        return {1'b0, sel} != INPUT_PINS;
    endfunction

    function automatic logic pin_level(logic [1:0] sel, logic [2:0] levels);
        logic lvl;
        lvl = 1'b0;
        if (pin_assigned(sel) && sel <= LAST_PIN) begin
            case (sel)
                2'd0:    lvl = levels[0];
                2'd1:    lvl = levels[1];
                2'd2:    lvl = levels[2];
                default: lvl = 1'b0;
            endcase
        end
        return lvl;
    endfunction

    function automatic logic [2:0] step_bits(cfg_t cfg, logic [2:0] levels);
        return {pin_level(cfg.step_high, levels),
                pin_level(cfg.step_mid, levels),
                pin_level(cfg.step_low, levels)};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/inverter_digital_input_commander_unit.sv
// Top level of the digital input commander: config, step table and pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat fields (low bit first)
// s_*       in   tuser: func; tdata: pin_levels[2:0] entry_index[5:3] entry_value[21:6]
// m_*       out  tdata: freq_write, cmd_freq, run/direction command, step_index,
//                edges_handled
// cfg_*     in   cfg_index: register number, cfg_data: value
//
// One beat per cycle sustained while m_tready is high. A taken beat is held
// in the decision stage, then in the output register that drives m_tvalid.
// The two register stages are the registered read of the step table (with
// the decision inputs) and the output register. Reset is synchronous and
// clears config, drive state and pipeline valids; the step table is not
// cleared. A stall on m_tready fills the decision stage and then holds
// s_tready low.

module inverter_digital_input_commander_unit
    import idic_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [23:0] s_tdata,   // pin_levels[2:0], entry_index[5:3], entry_value[21:6]
    input  wire logic        s_tuser,   // func

    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [31:0] m_tdata,   // freq_write[0], cmd_freq[16:1], run_command[18:17],
                                        // direction_command[20:19], step_index[23:21],
                                        // edges_handled[24]

    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [1:0]  cfg_data
);

    // ---------------- configuration ----------------
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.run_pin    <= INPUT_PINS[1:0];
            cfg_reg.dir_pin    <= INPUT_PINS[1:0];
            cfg_reg.step_low   <= INPUT_PINS[1:0];
            cfg_reg.step_mid   <= INPUT_PINS[1:0];
            cfg_reg.step_high  <= INPUT_PINS[1:0];
            cfg_reg.dir_domain <= 2'd0;
            cfg_reg.step_en    <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RUN_PIN:   cfg_reg.run_pin    <= cfg_data;
                CFG_DIR_PIN:   cfg_reg.dir_pin    <= cfg_data;
                CFG_STEP_LOW:  cfg_reg.step_low   <= cfg_data;
                CFG_STEP_MID:  cfg_reg.step_mid   <= cfg_data;
                CFG_STEP_HIGH: cfg_reg.step_high  <= cfg_data;
                CFG_DIR_DOM:   cfg_reg.dir_domain <= cfg_data;
                CFG_STEP_EN:   cfg_reg.step_en    <= cfg_data[0];
                default: ;     // index beyond the register list: ignored
            endcase
        end
    end

    // ---------------- input decode ----------------
    logic        in_func;
    logic [2:0]  in_levels;
    logic [2:0]  in_entry_idx;
    logic [15:0] in_entry_val;
    logic [2:0]  in_step_idx;
    logic        s_beat;

    assign in_func      = s_tuser;
    assign in_levels    = s_tdata[2:0];
    assign in_entry_idx = s_tdata[5:3];
    assign in_entry_val = s_tdata[21:6];
    assign in_step_idx  = step_bits(cfg_reg, in_levels);
    assign s_beat       = s_tvalid && s_tready;

    // ---------------- step frequency table ----------------
    // Written on a table beat, read at the step index on a sample beat.
    // Beats arrive at most one a cycle, so a read always sees earlier writes.
    logic [15:0] step_tbl [8];
    logic [15:0] tbl_rd_reg;

    always_ff @(posedge aclk) begin
        if (s_beat && in_func == FUNC_TABLE) begin
            step_tbl[in_entry_idx] <= in_entry_val;
        end
        if (s_beat) begin
            tbl_rd_reg <= step_tbl[in_step_idx];
        end
    end

    // ---------------- decision stage ----------------
    logic        dec_valid_reg;
    logic        dec_func_reg;
    logic [2:0]  dec_levels_reg;
    logic [2:0]  dec_step_reg;
    logic        dec_advance;

    logic        out_valid_reg;
    result_t     out_reg;

    drive_state_t state_reg;
    drive_state_t state_next;
    result_t      res_next;

    assign dec_advance = dec_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready    = !dec_valid_reg || dec_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg <= 1'b0;
        end else if (s_tready) begin
            dec_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            dec_func_reg   <= in_func;
            dec_levels_reg <= in_levels;
            dec_step_reg   <= in_step_idx;
        end
    end

    idic_cmd_logic u_cmd (
        .cfg        (cfg_reg),
        .func       (dec_func_reg),
        .levels     (dec_levels_reg),
        .step_idx   (dec_step_reg),
        .table_freq (tbl_rd_reg),
        .cur        (state_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    // drive state commits only when the beat moves into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (dec_advance) begin
            state_reg <= state_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (dec_advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dec_advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_reg.edges_handled,
                       out_reg.step_index,
                       out_reg.direction_command,
                       out_reg.run_command,
                       out_reg.cmd_freq,
                       out_reg.freq_write};

endmodule

`default_nettype wire

### hw/rtl/idic_cmd_logic.sv
// Command decision for one pin sample: frequency, run and direction edges.
`timescale 1ns / 1ps
`default_nettype none

module idic_cmd_logic
    import idic_pkg::*;
(
    input  cfg_t         cfg,
    input  logic         func,
    input  logic [2:0]   levels,
    input  logic [2:0]   step_idx,
    input  logic [15:0]  table_freq,
    input  drive_state_t cur,
    output drive_state_t nxt,
    output result_t      res
);

    logic any_step;
    logic run_lvl;
    logic dir_lvl;
    logic run_ok;
    logic handled;

    always_comb begin
        any_step = pin_assigned(cfg.step_low) || pin_assigned(cfg.step_mid) ||
                   pin_assigned(cfg.step_high);
        run_lvl  = pin_level(cfg.run_pin, levels);
        dir_lvl  = pin_level(cfg.dir_pin, levels);

        // Run may start only in a direction the domain permits.
        run_ok = 1'b1;
        if (pin_assigned(cfg.dir_pin)) begin
            if (cfg.dir_domain == DOM_FWD_ONLY && dir_lvl) run_ok = 1'b0;
            if (cfg.dir_domain == DOM_REV_ONLY && !dir_lvl) run_ok = 1'b0;
        end

        nxt     = cur;
        handled = 1'b1;
        res     = '0;

        if (func == FUNC_SAMPLE) begin
            res.step_index = step_idx;

            if (cfg.step_en && any_step && table_freq != cur.sent_freq) begin
                res.freq_write = 1'b1;
                nxt.sent_freq  = table_freq;
            end

            if (pin_assigned(cfg.run_pin)) begin
                if (!run_lvl && cur.run_level) begin
                    res.run_command = RUN_HALT;
                    nxt.run_level   = 1'b0;
                end else if (run_lvl && !cur.run_level) begin
                    // refused start keeps the old level so the next sample retries
                    if (run_ok) begin
                        res.run_command = RUN_GO;
                        nxt.run_level   = 1'b1;
                    end
                end else begin
                    handled = 1'b0;
                end
            end

            if (pin_assigned(cfg.dir_pin)) begin
                if (!dir_lvl && cur.dir_level) begin
                    if (cfg.dir_domain != DOM_REV_ONLY) begin
                        res.direction_command = DIR_FWD;
                        nxt.dir_level         = 1'b0;
                    end else begin
                        handled = 1'b0;
                    end
                end else if (dir_lvl && !cur.dir_level) begin
                    if (cfg.dir_domain != DOM_FWD_ONLY) begin
                        res.direction_command = DIR_REV;
                        nxt.dir_level         = 1'b1;
                    end else begin
                        handled = 1'b0;
                    end
                end else begin
                    handled = 1'b0;
                end
            end

            res.edges_handled = handled;
        end

        res.cmd_freq = nxt.sent_freq;
    end

endmodule

`default_nettype wire

### hw/rtl/idic_checker.sv
// Port-level checks on the digital input commander, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module idic_checker
    import idic_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    logic [15:0] seen_freq_reg;
    logic        m_beat;

    assign m_beat = m_tvalid && m_tready;

    // last frequency delivered on the result channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_freq_reg <= '0;
        end else if (m_beat) begin
            seen_freq_reg <= m_tdata[16:1];
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_freq_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat |-> (m_tdata[0] == (m_tdata[16:1] != seen_freq_reg)))
        else $error("freq_write does not match a change of commanded frequency");

    a_cmd_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:17] != 2'd3) && (m_tdata[20:19] != 2'd3))
        else $error("run or direction command holds an unused code");

endmodule

bind inverter_digital_input_commander_unit idic_checker u_idic_checker (.*);

`default_nettype wire
